// File: sv/selective_run_length_decoder_defines.svh
// Assertion macros shared by the selective run-length decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SELECTIVE_RUN_LENGTH_DECODER_DEFINES_SVH
`define SELECTIVE_RUN_LENGTH_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks a condition at every clock edge outside reset.
`define SRLD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Checks that a condition implies another in the same cycle.
`define SRLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that a condition implies another in the next cycle.
`define SRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRLD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SRLD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/srld_pkg.sv
// Types and constants of the selective run-length decoder.
// No dependencies; used by the interfaces and all modules of the block.
package srld_pkg;

  localparam int RUN_CHAR_SLOTS   = 4;
  localparam int COUNT_GROUPS_MAX = 4;
  localparam int CFG_REGS         = 4;

  localparam int BYTE_W   = 8;
  localparam int REPEAT_W = 28;
  localparam int GROUP_W  = 7;
  localparam int GIDX_W   = $clog2(COUNT_GROUPS_MAX + 1);
  localparam int SHIFT_W  = 6;
  localparam int WIDE_W   = 64;

  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [REPEAT_W-1:0] REPEAT_SAT = {REPEAT_W{1'b1}};

  typedef logic [RUN_CHAR_SLOTS-1:0][BYTE_W-1:0] run_chars_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   run_value;
    logic [REPEAT_W-1:0] run_repeat;
    logic                stream_end;
    logic                count_error;
  } srld_result_t;

endpackage

// File: sv/srld_if.sv
// Stream interfaces of the selective run-length decoder: byte input and result output.
// Depends on srld_pkg for field widths.
interface srld_in_if import srld_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface srld_out_if import srld_pkg::*;;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   run_value;
  logic [REPEAT_W-1:0] run_repeat;
  logic                stream_end;
  logic                count_error;

  modport source (output valid, output run_value, output run_repeat, output stream_end,
                  output count_error, input ready);
  modport sink   (input valid, input run_value, input run_repeat, input stream_end,
                  input count_error, output ready);
endinterface

// File: sv/srld_cfg.sv
// APB-style register file holding the run-enabled characters.
// Depends on srld_pkg.
module srld_cfg import srld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output run_chars_t         run_chars
);

  run_chars_t           run_chars_r;
  run_chars_t           run_chars_nxt;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_idx   = paddr[CFG_IDX_W+1:2];
  assign run_chars = run_chars_r;

  // Slots beyond the register list have no register and stay zero.
  always_comb begin
    run_chars_nxt = run_chars_r;
    for (int i = 0; i < RUN_CHAR_SLOTS; i++) begin
      if (wr_en && (i < CFG_REGS) && (int'(reg_idx) == i)) begin
        run_chars_nxt[i] = pwdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < RUN_CHAR_SLOTS; i++) begin
      if ((i < CFG_REGS) && (int'(reg_idx) == i)) begin
        prdata = {{(PDATA_W-BYTE_W){1'b0}}, run_chars_r[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_chars_r <= '0;
    end else begin
      run_chars_r <= run_chars_nxt;
    end
  end

endmodule

// File: sv/srld_decode.sv
// Per-byte decode step: character match, count group gathering and decoder state.
// Depends on srld_pkg and the assertion macro header.
`include "selective_run_length_decoder_defines.svh"
module srld_decode import srld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  run_chars_t        run_chars,
  output logic              res_valid,
  output srld_result_t      res
);

  localparam logic [GIDX_W-1:0] GIDX_MAX = GIDX_W'(COUNT_GROUPS_MAX);

  logic [BYTE_W-1:0]   pending_char_r, pending_char_nxt;
  logic [REPEAT_W-1:0] count_accum_r, count_accum_nxt;
  logic [GIDX_W-1:0]   group_index_r, group_index_nxt;
  logic                reading_r, reading_nxt;

  logic                is_run;
  logic [GROUP_W-1:0]  grp;
  logic                more;
  logic [SHIFT_W-1:0]  shift;
  logic [WIDE_W-1:0]   grp_sh;
  logic [REPEAT_W-1:0] acc_sum;
  logic [REPEAT_W-1:0] acc_fixed;
  logic [GIDX_W-1:0]   gidx_inc;

  always_comb begin
    is_run = 1'b0;
    for (int i = 0; i < RUN_CHAR_SLOTS; i++) begin
      if (run_chars[i] == in_byte) begin
        is_run = 1'b1;
      end
    end
  end

  assign grp    = in_byte[GROUP_W-1:0];
  assign more   = in_byte[BYTE_W-1];
  assign shift  = SHIFT_W'(GROUP_W * int'(group_index_r));
  assign grp_sh = {{(WIDE_W-GROUP_W){1'b0}}, grp} << shift;

  // Groups that would land above the count field saturate it.
  always_comb begin
    if (grp == '0) begin
      acc_sum = count_accum_r;
    end else if ((shift >= SHIFT_W'(REPEAT_W)) || (grp_sh[WIDE_W-1:REPEAT_W] != '0)) begin
      acc_sum = REPEAT_SAT;
    end else begin
      acc_sum = count_accum_r | grp_sh[REPEAT_W-1:0];
    end
  end

  assign acc_fixed = (acc_sum == '0) ? REPEAT_W'(1) : acc_sum;
  assign gidx_inc  = (group_index_r < GIDX_MAX) ? group_index_r + GIDX_W'(1) : group_index_r;

  always_comb begin
    pending_char_nxt = pending_char_r;
    count_accum_nxt  = count_accum_r;
    group_index_nxt  = group_index_r;
    reading_nxt      = reading_r;
    res_valid        = 1'b0;
    res.run_value    = in_byte;
    res.run_repeat   = REPEAT_W'(1);
    res.stream_end   = in_last;
    res.count_error  = 1'b0;
    if (accept) begin
      if (!reading_r) begin
        if (is_run && !in_last) begin
          pending_char_nxt = in_byte;
          count_accum_nxt  = '0;
          group_index_nxt  = '0;
          reading_nxt      = 1'b1;
        end else begin
          res_valid = 1'b1;
        end
      end else begin
        count_accum_nxt = acc_sum;
        group_index_nxt = gidx_inc;
        res.run_value   = pending_char_r;
        res.run_repeat  = acc_fixed;
        if (!more) begin
          res_valid   = 1'b1;
          reading_nxt = 1'b0;
        end else if (in_last || (gidx_inc >= GIDX_MAX)) begin
          // Count cut off by the end of the stream or too many groups.
          res_valid       = 1'b1;
          res.count_error = 1'b1;
          reading_nxt     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_char_r <= '0;
      count_accum_r  <= '0;
      group_index_r  <= '0;
      reading_r      <= 1'b0;
    end else begin
      pending_char_r <= pending_char_nxt;
      count_accum_r  <= count_accum_nxt;
      group_index_r  <= group_index_nxt;
      reading_r      <= reading_nxt;
    end
  end

  `SRLD_ASSERT_ALWAYS(a_gidx_range, clk, rst_n, group_index_r <= GIDX_MAX)
  `SRLD_ASSERT_SAME(a_repeat_nonzero, clk, rst_n, res_valid, res.run_repeat != '0)
  `SRLD_ASSERT_NEXT(a_enter_count, clk, rst_n, accept && !reading_r && is_run && !in_last,
                    reading_r && (pending_char_r == $past(in_byte)))
  `SRLD_ASSERT_SAME(a_error_in_count, clk, rst_n, res_valid && res.count_error,
                    reading_r && more)

endmodule

// File: sv/srld_out_reg.sv
// Result register between the decode step and the output channel.
// Depends on srld_pkg and the assertion macro header.
`include "selective_run_length_decoder_defines.svh"
module srld_out_reg import srld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  srld_result_t push_data,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output srld_result_t out_data
);

  logic         valid_r, valid_nxt;
  srld_result_t data_r, data_nxt;

  // A new beat may enter while the register is empty or the held result leaves in the same cycle.
  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (can_take) begin
      valid_nxt = push;
      if (push) begin
        data_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  `SRLD_ASSERT_NEXT(a_push_lands, clk, rst_n, push && can_take,
                    valid_r && (data_r == $past(push_data)))

endmodule

// File: sv/selective_run_length_decoder.sv
// Top level of the selective run-length decoder.
// Depends on srld_pkg, srld_if, srld_cfg, srld_decode and srld_out_reg.
//
//   Channel  Direction  Handshake           Carries
//   in_ch    in         valid/ready         in_byte, in_last
//   out_ch   out        valid/ready         run_value, run_repeat, stream_end, count_error
//   cfg      in         psel/penable/pready run_char_a..run_char_d at 0x0, 0x4, 0x8, 0xC
//
// One input beat is taken every cycle while the result register can take a result; its result, if any,
// appears on out_ch in the following cycle from the result register.
// The decode step handles each beat as it is taken, and the result register holds one entry.
// Reset (rst_n low, synchronous) clears the decoder state, the valid flag of the result
// register and the run characters to zero.
// A stalled output holds its result; input is taken only while the result
// register is empty or being drained in the same cycle.
module selective_run_length_decoder import srld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  srld_in_if.sink            in_ch,
  srld_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  run_chars_t   run_chars;
  logic         can_take;
  logic         accept;
  logic         res_valid;
  srld_result_t res;
  srld_result_t out_data;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  srld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .run_chars (run_chars)
  );

  srld_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .run_chars (run_chars),
    .res_valid (res_valid),
    .res       (res)
  );

  srld_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.run_value   = out_data.run_value;
  assign out_ch.run_repeat  = out_data.run_repeat;
  assign out_ch.stream_end  = out_data.stream_end;
  assign out_ch.count_error = out_data.count_error;

endmodule
